// File: hw/rtl/sha1_pkg.sv
package sha1_pkg;

	typedef logic [31:0] word_t;

	localparam int BLOCK_BYTES = 64;
	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int LEN_POS     = BLOCK_BYTES - 8;
	localparam int ROUNDS      = 80;
	localparam int RND_W       = $clog2(ROUNDS);
	localparam int DIGEST_WORDS = 5;
	localparam int OUT_W       = $clog2(DIGEST_WORDS);

	localparam logic [7:0] PAD_MARK_BYTE = 8'h80;

	localparam word_t IV0 = 32'h67452301;
	localparam word_t IV1 = 32'hEFCDAB89;
	localparam word_t IV2 = 32'h98BADCFE;
	localparam word_t IV3 = 32'h10325476;
	localparam word_t IV4 = 32'hC3D2E1F0;

	localparam word_t K0 = 32'h5A827999;
	localparam word_t K1 = 32'h6ED9EBA1;
	localparam word_t K2 = 32'h8F1BBCDC;
	localparam word_t K3 = 32'hCA62C1D6;

	// rotate left by a fixed amount
	function automatic word_t rotl(input word_t x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

// File: hw/rtl/sha1_hash_engine.sv
// channel | dir | tdata                 | tuser          | tlast
// s_*     | in  | data_byte [7:0]       | byte_valid [0] | last
// m_*     | out | digest_word [31:0]    | -              | digest_last
//
// a byte beat is taken in idle; the 64th byte of a block starts the rounds on the
// single shared round adder, followed by the chaining add
// a last beat starts the padding sequencer: one pad byte a cycle, except while a block
// is in its rounds, up to the end of one or two blocks, then five digest beats
// s_tready is high only in idle, so the input stalls for the whole block and digest time
// reset clears the sequencer, counters and length and loads the initial vector
// a stalled digest beat simply holds m_tdata and m_tlast until m_tready
module sha1_hash_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] byte_valid
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_ROUND,
		S_ADD,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_MARK,
		PH_ZERO,
		PH_LEN
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	logic [sha1_pkg::POS_W-1:0] pos_q;
	logic [sha1_pkg::RND_W-1:0] rnd_q;
	logic [sha1_pkg::OUT_W-1:0] out_idx_q;
	logic [2:0]                 len_cnt_q;
	logic [63:0]                msg_bits_q;
	logic                       pad_q;   // message is being finished
	logic                       fin_q;   // length bytes are in, digest follows

	sha1_pkg::word_t chain_q [sha1_pkg::DIGEST_WORDS];
	sha1_pkg::word_t win_q   [16];
	sha1_pkg::word_t a_q, b_q, c_q, d_q, e_q;

	// byte path into the schedule window
	logic       ab_en;
	logic [7:0] ab_byte;
	logic [7:0] pad_byte;
	logic       pos_end;
	logic       blk_done;
	logic [sha1_pkg::POS_W-1:0] pos_nxt;

	// round unit
	sha1_pkg::word_t f_val, k_val, t_val, w_new;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = chain_q[out_idx_q];
	assign m_tlast  = (out_idx_q == sha1_pkg::OUT_W'(sha1_pkg::DIGEST_WORDS - 1));

	always_comb begin
		case (phase_q)
			PH_MARK: pad_byte = sha1_pkg::PAD_MARK_BYTE;
			PH_LEN:  pad_byte = msg_bits_q[63:56];
			default: pad_byte = 8'h00;
		endcase
	end

	assign ab_en    = (s_tvalid && s_tready && s_tuser[0]) || (state_q == S_PAD);
	assign ab_byte  = (state_q == S_PAD) ? pad_byte : s_tdata;
	assign pos_end  = (pos_q == sha1_pkg::POS_W'(sha1_pkg::BLOCK_BYTES - 1));
	assign blk_done = ab_en && pos_end;
	assign pos_nxt  = pos_q + 1'b1;

	always_comb begin
		if (rnd_q < sha1_pkg::RND_W'(20)) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = sha1_pkg::K0;
		end else if (rnd_q < sha1_pkg::RND_W'(40)) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K1;
		end else if (rnd_q < sha1_pkg::RND_W'(60)) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = sha1_pkg::K2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = sha1_pkg::K3;
		end
		t_val = sha1_pkg::rotl(a_q, 5) + f_val + e_q + k_val + win_q[0];
		w_new = sha1_pkg::rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
	end

	// window and working variables, no reset needed
	always_ff @(posedge clk) begin
		if (ab_en) begin
			// whole window moves up one byte, first byte of the block ends in win_q[0] msb
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
			end
			win_q[15] <= {win_q[15][23:0], ab_byte};
			if (blk_done) begin
				a_q <= chain_q[0];
				b_q <= chain_q[1];
				c_q <= chain_q[2];
				d_q <= chain_q[3];
				e_q <= chain_q[4];
			end
		end else if (state_q == S_ROUND) begin
			// win_q[0] is always the word of the current round
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_new;
			a_q <= t_val;
			b_q <= a_q;
			c_q <= sha1_pkg::rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_MARK;
			pos_q      <= '0;
			rnd_q      <= '0;
			out_idx_q  <= '0;
			len_cnt_q  <= '0;
			msg_bits_q <= '0;
			pad_q      <= 1'b0;
			fin_q      <= 1'b0;
			chain_q[0] <= sha1_pkg::IV0;
			chain_q[1] <= sha1_pkg::IV1;
			chain_q[2] <= sha1_pkg::IV2;
			chain_q[3] <= sha1_pkg::IV3;
			chain_q[4] <= sha1_pkg::IV4;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						pad_q   <= s_tlast;
						phase_q <= PH_MARK;
						if (s_tuser[0]) begin
							msg_bits_q <= msg_bits_q + 64'd8;
							pos_q      <= pos_nxt;
							if (pos_end) begin
								state_q <= S_ROUND;
							end else if (s_tlast) begin
								state_q <= S_PAD;
							end
						end else if (s_tlast) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					pos_q <= pos_nxt;
					case (phase_q)
						PH_LEN: begin
							// length goes out msb first, register drains to zero
							msg_bits_q <= {msg_bits_q[55:0], 8'h00};
							len_cnt_q  <= len_cnt_q + 1'b1;
							if (len_cnt_q == 3'd7) begin
								fin_q <= 1'b1;
							end
						end
						default: begin
							if (pos_nxt == sha1_pkg::POS_W'(sha1_pkg::LEN_POS)) begin
								phase_q <= PH_LEN;
							end else begin
								phase_q <= PH_ZERO;
							end
						end
					endcase
					if (pos_end) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					if (rnd_q == sha1_pkg::RND_W'(sha1_pkg::ROUNDS - 1)) begin
						rnd_q   <= '0;
						state_q <= S_ADD;
					end else begin
						rnd_q <= rnd_q + 1'b1;
					end
				end
				S_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					if (fin_q) begin
						out_idx_q <= '0;
						state_q   <= S_OUT;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (m_tready) begin
						if (m_tlast) begin
							chain_q[0] <= sha1_pkg::IV0;
							chain_q[1] <= sha1_pkg::IV1;
							chain_q[2] <= sha1_pkg::IV2;
							chain_q[3] <= sha1_pkg::IV3;
							chain_q[4] <= sha1_pkg::IV4;
							pad_q      <= 1'b0;
							fin_q      <= 1'b0;
							out_idx_q  <= '0;
							state_q    <= S_IDLE;
						end else begin
							out_idx_q <= out_idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a finished digest leaves the block aligned with the length drained
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (pos_q == '0 && msg_bits_q == '0))
		else $error("state not clean after digest");

	// length bytes only occupy the final eight byte slots of a block
	a_len_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PAD && phase_q == PH_LEN) |-> (pos_q[sha1_pkg::POS_W-1:3] == '1))
		else $error("length byte outside its slot");

	// the last round is always followed by the chaining add
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == sha1_pkg::RND_W'(sha1_pkg::ROUNDS - 1))
		|=> (state_q == S_ADD))
		else $error("round count overran");

	// digest beats start only once the length is in and a block has closed
	a_out_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> (fin_q && pos_q == '0 && $past(state_q) == S_ADD))
		else $error("digest without completed padding");

endmodule
